>>> hw/rtl/sdd_pkg.sv
// sdd_pkg: types, constants and calendar tables for the date difference block
// no dependencies; used by sdd_day_num, sdd_diff and the top level
package sdd_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int DAY_NUM_W  = 23;
  localparam int DIFF_W     = 23;
  localparam int WIDE_W     = DAY_NUM_W + 2;

  // shifted year = year + 400 - (month <= 2)
  localparam int SHIFT_YEAR_W = YEAR_W + 1;
  localparam logic [SHIFT_YEAR_W-1:0] YEAR_OFFSET = SHIFT_YEAR_W'(400);

  // x / 100 == (x * 5243) >> 19, exact for x below 2**15
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
  localparam int RECIP_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP  = DAY_W'(29);
  localparam logic [DAY_W-1:0]   FEB_PLAIN = DAY_W'(28);

  localparam logic signed [WIDE_W-1:0] DIFF_MAX = WIDE_W'(4194303);
  localparam logic signed [WIDE_W-1:0] DIFF_MIN = -WIDE_W'(4194304);

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               include_end_day;
  } in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     invalid_date;
  } out_t;

  // month length, with february as in a plain year; zero for impossible months
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = FEB_PLAIN;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // days before the month in a year starting in march
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] ofs;
    case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

>>> hw/rtl/sdd_day_num.sv
// sdd_day_num: day number and validity check of one calendar date
// depends on sdd_pkg
module sdd_day_num
  import sdd_pkg::*;
(
  input  logic [YEAR_W-1:0]    year,
  input  logic [MONTH_W-1:0]   month,
  input  logic [DAY_W-1:0]     day,
  output logic [DAY_NUM_W-1:0] day_num,
  output logic                 date_ok
);

  localparam int PROD_W   = SHIFT_YEAR_W + RECIP_W;
  localparam int PROD_Y_W = YEAR_W + RECIP_W;

  logic                      early;
  logic [SHIFT_YEAR_W-1:0]   yy;
  logic [PROD_W-1:0]         prod_yy;
  logic [PROD_W-RECIP_SHIFT-1:0] cent_yy;
  logic [PROD_Y_W-1:0]       prod_y;
  logic [PROD_Y_W-RECIP_SHIFT-1:0] cent_y;
  logic                      centurial;
  logic                      leap;
  logic [DAY_W-1:0]          len;

  // leap year test on the plain year
  assign prod_y    = PROD_Y_W'(year) * PROD_Y_W'(RECIP_100);
  assign cent_y    = prod_y[PROD_Y_W-1:RECIP_SHIFT];
  assign centurial = (YEAR_W'(cent_y) * YEAR_W'(100)) == year;
  assign leap      = (year[1:0] == 2'b00) && (!centurial || (cent_y[1:0] == 2'b00));

  assign len     = (month == MONTH_FEB) ? (leap ? FEB_LEAP : FEB_PLAIN) : month_len(month);
  assign date_ok = (month != '0) && (month <= MONTH_DEC) && (day != '0) && (day <= len);

  // day count with the year starting in march
  assign early   = (month <= MONTH_FEB);
  assign yy      = SHIFT_YEAR_W'(year) + YEAR_OFFSET - SHIFT_YEAR_W'(early);
  assign prod_yy = PROD_W'(yy) * PROD_W'(RECIP_100);
  assign cent_yy = prod_yy[PROD_W-1:RECIP_SHIFT];

  assign day_num = DAY_NUM_W'(yy) * DAY_NUM_W'(365)
                 + DAY_NUM_W'(yy[SHIFT_YEAR_W-1:2])
                 - DAY_NUM_W'(cent_yy)
                 + DAY_NUM_W'(cent_yy[PROD_W-RECIP_SHIFT-1:2])
                 + DAY_NUM_W'(month_offset(month))
                 + DAY_NUM_W'(day);

endmodule

>>> hw/rtl/sdd_diff.sv
// sdd_diff: signed difference of two day numbers with end-day and saturation
// depends on sdd_pkg and sdd_day_num
module sdd_diff
  import sdd_pkg::*;
(
  input  in_t  item,
  output out_t result
);

  logic [DAY_NUM_W-1:0]      num_first;
  logic [DAY_NUM_W-1:0]      num_second;
  logic                      ok_first;
  logic                      ok_second;
  logic signed [WIDE_W-1:0]  raw;
  logic signed [WIDE_W-1:0]  adj;
  logic signed [WIDE_W-1:0]  sat;

  sdd_day_num u_first (
    .year    (item.first_year),
    .month   (item.first_month),
    .day     (item.first_day),
    .day_num (num_first),
    .date_ok (ok_first)
  );

  sdd_day_num u_second (
    .year    (item.second_year),
    .month   (item.second_month),
    .day     (item.second_day),
    .day_num (num_second),
    .date_ok (ok_second)
  );

  always_comb begin
    raw = $signed({2'b00, num_second}) - $signed({2'b00, num_first});
    if (item.include_end_day) begin
      adj = (raw > 0) ? raw + WIDE_W'(1) : raw - WIDE_W'(1);
    end else begin
      adj = raw;
    end
    if (adj > DIFF_MAX) begin
      sat = DIFF_MAX;
    end else if (adj < DIFF_MIN) begin
      sat = DIFF_MIN;
    end else begin
      sat = adj;
    end
    if (ok_first && ok_second) begin
      result.day_difference = sat[DIFF_W-1:0];
      result.invalid_date   = 1'b0;
    end else begin
      result.day_difference = '0;
      result.invalid_date   = 1'b1;
    end
  end

endmodule

>>> hw/rtl/signed_day_difference_between_dates.sv
// signed_day_difference_between_dates: top level of the date difference block
// depends on sdd_pkg and sdd_diff
//
// usage
// - input channel in_valid/in_ready/in_data carries two dates and the end-day flag
// - result channel out_valid/out_ready/out_data carries the signed day count and
//   an invalid-date flag; exactly one result word per input word, in order
// - an accepted word lands in an input register; the day numbers, difference and
//   saturation are formed in one pass and captured in the result register
// - after acceptance the word moves from the input register into the result register,
//   and out_valid rises once the result register holds it
// - one word per cycle while out_ready stays high, set by the single compute stage
// - a stalled receiver holds the result register; the input register still takes
//   one more word, then in_ready drops until out_ready returns
// - reset (rst_n low, synchronous) empties both registers; no state survives
//   between words
module signed_day_difference_between_dates
  import sdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic in_full_r;
  logic in_full_nxt;
  in_t  in_hold_r;
  logic out_full_r;
  logic out_full_nxt;
  out_t out_hold_r;
  out_t result;
  logic out_take;
  logic move;

  assign out_take = !out_full_r || out_ready;
  assign in_ready = !in_full_r || out_take;
  assign move     = in_full_r && out_take;

  assign in_full_nxt  = (in_valid && in_ready) ? 1'b1 : (move ? 1'b0 : in_full_r);
  assign out_full_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_full_r);

  sdd_diff u_diff (
    .item   (in_hold_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold_r <= in_data;
    end
    if (move) begin
      out_hold_r <= result;
    end
  end

  assign out_valid = out_full_r;
  assign out_data  = out_hold_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !in_full_r && !out_full_r)
    else $error("registers not empty after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r && out_hold_r.invalid_date |-> out_hold_r.day_difference == '0)
    else $error("invalid date with nonzero difference");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && out_full_r && !out_ready |-> !in_ready)
    else $error("input taken while both registers are full");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_full_r)
    else $error("result register not filled after transfer");

endmodule
